@@ rtl/pbtn_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and codes for the particle bounce and two-nearest block.
package pbtn_pkg;

    localparam int BALL_SLOTS = 64;
    localparam int ADDR_W     = $clog2(BALL_SLOTS);
    localparam int CNT_W      = $clog2(BALL_SLOTS + 1);

    localparam int POS_W  = 24;
    localparam int VEL_W  = 10;
    localparam int SIZE_W = 11;
    localparam int LIM_W  = 12;
    localparam int BCNT_W = 7;
    localparam int DIST_W = 40;
    localparam int CIDX_W = 2;

    localparam logic [LIM_W-1:0]  AREA_WIDTH_RST   = 12'd1280;
    localparam logic [LIM_W-1:0]  AREA_HEIGHT_RST  = 12'd720;
    localparam logic [LIM_W-1:0]  MAX_DISTANCE_RST = 12'd100;
    localparam logic [BCNT_W-1:0] BALL_COUNT_RST   = 7'd50;

    localparam logic [CIDX_W-1:0] CFG_AREA_WIDTH   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_AREA_HEIGHT  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_DISTANCE = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_BALL_COUNT   = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [SIZE_W-1:0]       size;
    } t_ball;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
        logic [DIST_W-1:0] d;
    } t_dist;

    typedef struct packed {
        logic              f1;
        logic [ADDR_W-1:0] i1;
        logic [DIST_W-1:0] d1;
        logic              f2;
        logic [ADDR_W-1:0] i2;
        logic [DIST_W-1:0] d2;
    } t_rank;

endpackage

@@ rtl/particle_bounce_two_nearest_core.sv @@
`timescale 1ns / 1ps
// Top level: particle table, step/bounce update and two-nearest neighbor scan.
//
//  channel | direction | handshake              | words
//  in      | in        | i_in_valid / o_in_stall | op, index, load position/velocity/size
//  out     | out       | o_out_valid / i_out_stall | index, new position, two neighbors
//  cfg     | in        | i_cfg_valid / o_cfg_ready | register index, write data
//
// During a step's scan, one table word is read per cycle over the single RAM
// read port.
// Synchronous active-low reset clears control and config; the table is not cleared.
// A held result in the output register does not block the next word's work;
// only finishing a word waits for that register to drain.
module particle_bounce_two_nearest_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic [5:0]                            i_ball_index,
    input  logic signed [pbtn_pkg::POS_W-1:0]     i_load_pos_x,
    input  logic signed [pbtn_pkg::POS_W-1:0]     i_load_pos_y,
    input  logic signed [pbtn_pkg::VEL_W-1:0]     i_load_vel_x,
    input  logic signed [pbtn_pkg::VEL_W-1:0]     i_load_vel_y,
    input  logic [pbtn_pkg::SIZE_W-1:0]           i_load_size,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [5:0]                            o_out_index,
    output logic signed [pbtn_pkg::POS_W-1:0]     o_new_pos_x,
    output logic signed [pbtn_pkg::POS_W-1:0]     o_new_pos_y,
    output logic                                  o_nearest_found,
    output logic [5:0]                            o_nearest_index,
    output logic [pbtn_pkg::DIST_W-1:0]           o_nearest_dist_sq,
    output logic                                  o_second_found,
    output logic [5:0]                            o_second_index,
    output logic [pbtn_pkg::DIST_W-1:0]           o_second_dist_sq,
    output logic                                  o_draw_triangle,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pbtn_pkg::CIDX_W-1:0]           i_cfg_index,
    input  logic [pbtn_pkg::LIM_W-1:0]            i_cfg_data
);

    localparam int ADDR_W = pbtn_pkg::ADDR_W;
    localparam int CNT_W  = pbtn_pkg::CNT_W;
    localparam int POS_W  = pbtn_pkg::POS_W;
    localparam int VEL_W  = pbtn_pkg::VEL_W;
    localparam int SIZE_W = pbtn_pkg::SIZE_W;
    localparam int LIM_W  = pbtn_pkg::LIM_W;
    localparam int DIST_W = pbtn_pkg::DIST_W;
    localparam int BALL_W = $bits(pbtn_pkg::t_ball);

    // config
    logic [LIM_W-1:0]            r_area_width, r_area_height, r_max_distance;
    logic [pbtn_pkg::BCNT_W-1:0] r_ball_count;

    // control
    pbtn_pkg::t_state  r_state, n_state;
    logic              r_out_valid;
    logic              r_rd_valid;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [CNT_W-1:0]  r_j;

    // work registers
    logic                    r_op;
    logic [ADDR_W-1:0]       r_idx;
    logic signed [POS_W-1:0] r_px, r_py;
    logic signed [VEL_W-1:0] r_vx, r_vy;
    logic [SIZE_W-1:0]       r_sz;
    logic [DIST_W-1:0]       r_mdsq;

    // output register
    logic [ADDR_W-1:0]       r_o_index, r_o_i1, r_o_i2;
    logic signed [POS_W-1:0] r_o_px, r_o_py;
    logic                    r_o_f1, r_o_f2, r_o_draw;
    logic [DIST_W-1:0]       r_o_d1, r_o_d2;

    logic                  in_acc, out_acc, out_free;
    logic [CNT_W-1:0]      scan_n;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    pbtn_pkg::t_ball       ram_wdata, ram_rdata, upd_word, load_word;
    logic [2*LIM_W-1:0]    md2;
    logic                  dist_busy;
    pbtn_pkg::t_dist       sq_dist;
    pbtn_pkg::t_rank       rank;

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] pos,
        input logic signed [VEL_W-1:0] vel
    );
        logic signed [POS_W:0] s;
        s = $signed({pos[POS_W-1], pos}) + $signed({{(POS_W+1-VEL_W){vel[VEL_W-1]}}, vel});
        if (s[POS_W] != s[POS_W-1]) begin
            sat_add = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_add = s[POS_W-1:0];
        end
    endfunction

    function automatic logic at_edge(
        input logic signed [POS_W-1:0] pos,
        input logic [SIZE_W-1:0]       sz,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [POS_W+2:0] p2, lo, hi, bound;
        p2    = $signed({{2{pos[POS_W-1]}}, pos, 1'b0});
        lo    = p2 - $signed({{(POS_W+3-SIZE_W){1'b0}}, sz});
        hi    = p2 + $signed({{(POS_W+3-SIZE_W){1'b0}}, sz});
        bound = $signed({{(POS_W-6-LIM_W){1'b0}}, lim, 9'b0});
        at_edge = (lo <= 0) || (hi >= bound);
    endfunction

    function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
        if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
            neg_vel = {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            neg_vel = -v;
        end
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign scan_n   = (r_ball_count > CNT_W'(pbtn_pkg::BALL_SLOTS))
                    ? CNT_W'(pbtn_pkg::BALL_SLOTS) : CNT_W'(r_ball_count);
    assign md2      = (2*LIM_W)'(r_max_distance) * (2*LIM_W)'(r_max_distance);

    assign o_in_stall  = (r_state != pbtn_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_width   <= pbtn_pkg::AREA_WIDTH_RST;
            r_area_height  <= pbtn_pkg::AREA_HEIGHT_RST;
            r_max_distance <= pbtn_pkg::MAX_DISTANCE_RST;
            r_ball_count   <= pbtn_pkg::BALL_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pbtn_pkg::CFG_AREA_WIDTH:   r_area_width   <= i_cfg_data;
                pbtn_pkg::CFG_AREA_HEIGHT:  r_area_height  <= i_cfg_data;
                pbtn_pkg::CFG_MAX_DISTANCE: r_max_distance <= i_cfg_data;
                pbtn_pkg::CFG_BALL_COUNT:   r_ball_count   <= i_cfg_data[pbtn_pkg::BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // table RAM
    always_comb begin
        load_word.pos_x = i_load_pos_x;
        load_word.pos_y = i_load_pos_y;
        load_word.vel_x = i_load_vel_x;
        load_word.vel_y = i_load_vel_y;
        load_word.size  = i_load_size;
        upd_word.pos_x  = r_px;
        upd_word.pos_y  = r_py;
        upd_word.vel_x  = at_edge(r_px, r_sz, r_area_width) ? neg_vel(r_vx) : r_vx;
        upd_word.vel_y  = at_edge(r_py, r_sz, r_area_height) ? neg_vel(r_vy) : r_vy;
        upd_word.size   = r_sz;
        ram_we    = (in_acc && i_op == pbtn_pkg::OP_LOAD) || (r_state == pbtn_pkg::ST_UPD);
        ram_waddr = (r_state == pbtn_pkg::ST_UPD) ? r_idx : i_ball_index[ADDR_W-1:0];
        ram_wdata = (r_state == pbtn_pkg::ST_UPD) ? upd_word : load_word;
        ram_raddr = (r_state == pbtn_pkg::ST_SCAN) ? r_j[ADDR_W-1:0] : i_ball_index[ADDR_W-1:0];
    end

    pbtn_ram #(
        .WIDTH (BALL_W),
        .DEPTH (pbtn_pkg::BALL_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pbtn_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_qx    (ram_rdata.pos_x),
        .i_qy    (ram_rdata.pos_y),
        .i_mdsq  (r_mdsq),
        .o_dist  (sq_dist),
        .o_busy  (dist_busy)
    );

    pbtn_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (r_state == pbtn_pkg::ST_UPD),
        .i_dist  (sq_dist),
        .o_rank  (rank)
    );

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbtn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbtn_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_op == pbtn_pkg::OP_STEP) ? pbtn_pkg::ST_RD : pbtn_pkg::ST_FIN;
                end
            end
            pbtn_pkg::ST_RD:   n_state = pbtn_pkg::ST_UPD;
            pbtn_pkg::ST_UPD: begin
                n_state = (scan_n == '0) ? pbtn_pkg::ST_DRAIN : pbtn_pkg::ST_SCAN;
            end
            pbtn_pkg::ST_SCAN: begin
                if (r_j + CNT_W'(1) == scan_n) begin
                    n_state = pbtn_pkg::ST_DRAIN;
                end
            end
            pbtn_pkg::ST_DRAIN: begin
                if (!r_rd_valid && !dist_busy) begin
                    n_state = pbtn_pkg::ST_FIN;
                end
            end
            pbtn_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = pbtn_pkg::ST_IDLE;
                end
            end
            default: n_state = pbtn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_j         <= '0;
        end else begin
            if (r_state == pbtn_pkg::ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            r_rd_valid <= (r_state == pbtn_pkg::ST_SCAN) && (r_j[ADDR_W-1:0] != r_idx);
            if (r_state == pbtn_pkg::ST_UPD) begin
                r_j <= '0;
            end else if (r_state == pbtn_pkg::ST_SCAN) begin
                r_j <= r_j + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_j[ADDR_W-1:0];
        if (in_acc) begin
            r_op  <= i_op;
            r_idx <= i_ball_index[ADDR_W-1:0];
            r_px  <= i_load_pos_x;
            r_py  <= i_load_pos_y;
        end else if (r_state == pbtn_pkg::ST_RD) begin
            r_px   <= sat_add(ram_rdata.pos_x, ram_rdata.vel_x);
            r_py   <= sat_add(ram_rdata.pos_y, ram_rdata.vel_y);
            r_vx   <= ram_rdata.vel_x;
            r_vy   <= ram_rdata.vel_y;
            r_sz   <= ram_rdata.size;
            r_mdsq <= {md2, 16'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pbtn_pkg::ST_FIN && out_free) begin
            r_o_index <= r_idx;
            r_o_px    <= r_px;
            r_o_py    <= r_py;
            if (r_op == pbtn_pkg::OP_STEP) begin
                r_o_f1   <= rank.f1;
                r_o_i1   <= rank.f1 ? rank.i1 : '0;
                r_o_d1   <= rank.f1 ? rank.d1 : '0;
                r_o_f2   <= rank.f2;
                r_o_i2   <= rank.f2 ? rank.i2 : '0;
                r_o_d2   <= rank.f2 ? rank.d2 : '0;
                r_o_draw <= rank.f2 && (rank.d2 < r_mdsq);
            end else begin
                r_o_f1   <= 1'b0;
                r_o_i1   <= '0;
                r_o_d1   <= '0;
                r_o_f2   <= 1'b0;
                r_o_i2   <= '0;
                r_o_d2   <= '0;
                r_o_draw <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_index       = 6'(r_o_index);
    assign o_new_pos_x       = r_o_px;
    assign o_new_pos_y       = r_o_py;
    assign o_nearest_found   = r_o_f1;
    assign o_nearest_index   = 6'(r_o_i1);
    assign o_nearest_dist_sq = r_o_d1;
    assign o_second_found    = r_o_f2;
    assign o_second_index    = 6'(r_o_i2);
    assign o_second_dist_sq  = r_o_d2;
    assign o_draw_triangle   = r_o_draw;

`ifndef ASSERT_OFF
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbtn_pkg::ST_FIN && r_out_valid && i_out_stall) |=> r_state == pbtn_pkg::ST_FIN)
        else $error("finished word overran a held result");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pbtn_pkg::ST_SCAN |-> r_j < scan_n)
        else $error("scan index past table");
    a_no_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_dist.valid |-> sq_dist.idx != r_idx)
        else $error("stepped entry entered neighbor scan");
    a_draw_needs_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_draw) |-> (r_o_f2 && r_o_f1))
        else $error("triangle flag without two neighbors");
`endif

endmodule

@@ rtl/pbtn_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port RAM, one write port, one registered read port.
module pbtn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pbtn_dist.sv @@
`timescale 1ns / 1ps
// Three-stage squared-distance pipeline with radius check.
module pbtn_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [pbtn_pkg::ADDR_W-1:0]          i_idx,
    input  logic signed [pbtn_pkg::POS_W-1:0]    i_px,
    input  logic signed [pbtn_pkg::POS_W-1:0]    i_py,
    input  logic signed [pbtn_pkg::POS_W-1:0]    i_qx,
    input  logic signed [pbtn_pkg::POS_W-1:0]    i_qy,
    input  logic [pbtn_pkg::DIST_W-1:0]          i_mdsq,
    output pbtn_pkg::t_dist                      o_dist,
    output logic                                 o_busy
);

    localparam int DW = pbtn_pkg::POS_W + 1;
    localparam int SQ_W = 2 * DW - 1;

    logic                     r_v1, r_v2, r_v3;
    logic [pbtn_pkg::ADDR_W-1:0] r_i1, r_i2, r_i3;
    logic signed [DW-1:0]     r_dx, r_dy;
    logic [SQ_W-1:0]          r_sqx, r_sqy;
    logic [pbtn_pkg::DIST_W-1:0] r_d;

    logic signed [DW-1:0]     n_dx, n_dy;
    logic signed [2*DW-1:0]   n_px2, n_py2;
    logic [2*DW-1:0]          n_sum;
    logic                     n_ok;

    always_comb begin
        n_dx  = $signed({i_px[pbtn_pkg::POS_W-1], i_px}) - $signed({i_qx[pbtn_pkg::POS_W-1], i_qx});
        n_dy  = $signed({i_py[pbtn_pkg::POS_W-1], i_py}) - $signed({i_qy[pbtn_pkg::POS_W-1], i_qy});
        n_px2 = r_dx * r_dx;
        n_py2 = r_dy * r_dy;
        n_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
        n_ok  = n_sum <= {{(2*DW-pbtn_pkg::DIST_W){1'b0}}, i_mdsq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_i1  <= i_idx;
        r_sqx <= n_px2[SQ_W-1:0];
        r_sqy <= n_py2[SQ_W-1:0];
        r_i2  <= r_i1;
        r_d   <= n_sum[pbtn_pkg::DIST_W-1:0];
        r_i3  <= r_i2;
    end

    assign o_dist.valid = r_v3;
    assign o_dist.idx   = r_i3;
    assign o_dist.d     = r_d;
    assign o_busy       = r_v1 || r_v2 || r_v3;

endmodule

@@ rtl/pbtn_rank.sv @@
`timescale 1ns / 1ps
// Running nearest and second-nearest tracker; ties replace.
module pbtn_rank (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  pbtn_pkg::t_dist i_dist,
    output pbtn_pkg::t_rank o_rank
);

    pbtn_pkg::t_rank r_rank;
    pbtn_pkg::t_rank n_rank;

    always_comb begin
        n_rank = r_rank;
        if (i_clear) begin
            n_rank.f1 = 1'b0;
            n_rank.f2 = 1'b0;
        end else if (i_dist.valid) begin
            if (!r_rank.f1 || i_dist.d <= r_rank.d1) begin
                if (r_rank.f1) begin
                    n_rank.f2 = 1'b1;
                    n_rank.i2 = r_rank.i1;
                    n_rank.d2 = r_rank.d1;
                end
                n_rank.f1 = 1'b1;
                n_rank.i1 = i_dist.idx;
                n_rank.d1 = i_dist.d;
            end else if (!r_rank.f2 || i_dist.d <= r_rank.d2) begin
                n_rank.f2 = 1'b1;
                n_rank.i2 = i_dist.idx;
                n_rank.d2 = i_dist.d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank.f1 <= 1'b0;
            r_rank.f2 <= 1'b0;
        end else begin
            r_rank.f1 <= n_rank.f1;
            r_rank.f2 <= n_rank.f2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank.i1 <= n_rank.i1;
        r_rank.d1 <= n_rank.d1;
        r_rank.i2 <= n_rank.i2;
        r_rank.d2 <= n_rank.d2;
    end

    assign o_rank = r_rank;

`ifndef ASSERT_OFF
    a_second_not_nearer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rank.f2 |-> (r_rank.f1 && r_rank.d2 >= r_rank.d1))
        else $error("second neighbor nearer than nearest");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (!r_rank.f1 && !r_rank.f2))
        else $error("rank not cleared");
`endif

endmodule
